// ===== hdl/tilt_pd_motor_mixer_top_assert.svh =====
// assertion macros for the tilt mixer
`ifndef TILT_PD_MOTOR_MIXER_TOP_ASSERT_SVH
`define TILT_PD_MOTOR_MIXER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TPM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define TPM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TPM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/tpm_pkg.sv =====
package tpm_pkg;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam logic signed [16:0] EFFORT_ONE = 17'sd16384;
   localparam logic [1:0] REG_P_GAIN = 2'd0;
   localparam logic [1:0] REG_D_GAIN = 2'd1;
   localparam logic [1:0] REG_SMOOTHING = 2'd2;
   localparam logic [1:0] REG_MOTOR_SCALE = 2'd3;

   typedef struct packed {
      logic load;
      logic sqrt_step;
      logic cordic_init;
      logic cordic_step;
      logic [2:0] post_step;
   } cmd_type;

   typedef struct packed {
      logic sqrt_last;
      logic cordic_last;
   } status_type;

   localparam logic [2:0] POST_NONE = 3'd0;
   localparam logic [2:0] POST_ANGLE = 3'd1;
   localparam logic [2:0] POST_FILT = 3'd2;
   localparam logic [2:0] POST_ACC = 3'd3;
   localparam logic [2:0] POST_EFF = 3'd4;
   localparam logic [2:0] POST_MIX = 3'd5;

   function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
      logic signed [31:0] t;
      unique case (i)
         5'd0: t = 32'sd843314856;  5'd1: t = 32'sd497837829;
         5'd2: t = 32'sd263043836;  5'd3: t = 32'sd133525158;
         5'd4: t = 32'sd67021686;   5'd5: t = 32'sd33543515;
         5'd6: t = 32'sd16775850;   5'd7: t = 32'sd8388437;
         5'd8: t = 32'sd4194282;    5'd9: t = 32'sd2097149;
         5'd10: t = 32'sd1048575;   5'd11: t = 32'sd524287;
         5'd12: t = 32'sd262143;    5'd13: t = 32'sd131071;
         5'd14: t = 32'sd65535;     5'd15: t = 32'sd32767;
         5'd16: t = 32'sd16383;     5'd17: t = 32'sd8191;
         5'd18: t = 32'sd4095;      5'd19: t = 32'sd2047;
         5'd20: t = 32'sd1023;      5'd21: t = 32'sd511;
         5'd22: t = 32'sd255;       5'd23: t = 32'sd127;
         default: t = 32'sd0;
      endcase
      return t;
   endfunction
endpackage

// ===== hdl/tpm_ctrl.sv =====
module tpm_ctrl
   import tpm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic out_taken,
   input  status_type status,
   output cmd_type cmd,
   output logic out_load,
   output logic busy,
   output logic out_valid
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQRT = 3'd1;
   localparam logic [2:0] S_CORD = 3'd2;
   localparam logic [2:0] S_POST = 3'd3;
   localparam logic [2:0] S_OUT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] post_ff, post_in;
   logic valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      post_in = post_ff;
      valid_in = valid_ff && !out_taken;
      cmd = '0;
      out_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (status.sqrt_last) begin
               state_in = S_CORD;
            end
         end
         S_CORD: begin
            if (post_ff == POST_NONE) begin
               cmd.cordic_init = 1'b1;
               post_in = POST_ANGLE;
            end else begin
               cmd.cordic_step = 1'b1;
               if (status.cordic_last) begin
                  state_in = S_POST;
               end
            end
         end
         S_POST: begin
            cmd.post_step = post_ff;
            if (post_ff == POST_MIX) begin
               state_in = S_OUT;
               post_in = POST_NONE;
            end else begin
               post_in = post_ff + 3'd1;
            end
         end
         S_OUT: begin
            // wait until the output register is free
            if (!valid_ff || out_taken) begin
               valid_in = 1'b1;
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         post_ff <= POST_NONE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         post_ff <= post_in;
         valid_ff <= valid_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign out_valid = valid_ff;
endmodule

// ===== hdl/tpm_datapath.sv =====
module tpm_datapath
   import tpm_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output status_type status,
   input  logic signed [15:0] accel_x,
   input  logic signed [15:0] accel_y,
   input  logic signed [15:0] accel_z,
   input  logic signed [15:0] gyro_pitch_rate,
   input  logic out_load,
   input  logic [15:0] p_gain,
   input  logic [15:0] d_gain,
   input  logic [15:0] smoothing,
   input  logic [14:0] motor_scale,
   output logic [15:0] motor_front,
   output logic [15:0] motor_back,
   output logic signed [15:0] control_effort
);
   localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam logic [4:0] LAST = 5'(NSTEP - 1);

   // radicand up to 2^47, result 24 bits, one result bit per cycle
   logic [47:0] rem_ff, rem_in;
   logic [23:0] root_ff, root_in;
   logic [4:0] cnt_ff, cnt_in;
   logic signed [15:0] ax_ff, gyro_ff;
   logic signed [33:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [33:0] ang_ff, ang_in;
   logic zero_ff, zero_in;
   logic signed [15:0] s_ff, s_in, raw_ff, raw_in, pitch_ff, pitch_in;
   logic signed [17:0] dp_ff, dp_in;
   logic signed [38:0] acc_ff, acc_in;
   logic signed [16:0] eff_ff, eff_in;
   logic [15:0] front_ff, front_in, back_ff, back_in;
   logic [15:0] mf_ff, mb_ff;
   logic signed [15:0] me_ff;

   logic signed [31:0] ay32, az32;
   logic [31:0] sq;
   logic signed [33:0] shx, shy;
   logic signed [33:0] mulf;
   logic signed [33:0] pterm, dterm;
   logic signed [38:0] eff3;
   logic signed [23:0] effs;
   logic [31:0] pf, pb;

   always_comb begin
      ay32 = 32'(accel_y);
      az32 = 32'(accel_z);
      sq = $unsigned(ay32 * ay32) + $unsigned(az32 * az32);
      rem_in = rem_ff; root_in = root_ff; cnt_in = cnt_ff;
      vx_in = vx_ff; vy_in = vy_ff; ang_in = ang_ff; zero_in = zero_ff;
      s_in = s_ff; raw_in = raw_ff; pitch_in = pitch_ff; dp_in = dp_ff;
      acc_in = acc_ff; eff_in = eff_ff; front_in = front_ff; back_in = back_ff;
      shx = vx_ff >>> cnt_ff;
      shy = vy_ff >>> cnt_ff;
      mulf = 34'($signed({1'b0, smoothing})) * (34'(raw_ff) - 34'(s_ff)) + 34'sd32768;
      pterm = 34'($signed({1'b0, p_gain, 1'b0})) * 34'(pitch_ff);
      dterm = 34'($signed({1'b0, d_gain})) * 34'(dp_ff);
      eff3 = 39'(acc_ff * 3) + 39'sd16384;
      effs = 24'(eff3 >>> 15);
      pf = 32'(motor_scale) * 32'(17'(EFFORT_ONE - eff_ff));
      pb = 32'(motor_scale) * 32'(17'(EFFORT_ONE + eff_ff));
      if (cmd.load) begin
         rem_in = {sq, 16'd0};
         root_in = '0;
         cnt_in = 5'd23;
      end
      if (cmd.sqrt_step) begin
         // restoring root: test (4r+1)<<2k against remainder window
         if ({24'd0, root_ff, 2'b01} <= {2'b00, rem_ff[47:0]} >> (2 * cnt_ff)) begin
            rem_in = rem_ff - (48'({root_ff, 2'b01}) << (2 * cnt_ff));
            root_in = {root_ff[22:0], 1'b1};
         end else begin
            root_in = {root_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
      end
      if (cmd.cordic_init) begin
         vx_in = 34'($signed({1'b0, root_ff}));
         vy_in = -34'(ax_ff) * 34'sd256;
         ang_in = '0;
         cnt_in = '0;
         zero_in = (root_ff == 24'd0) && (ax_ff == 16'sd0);
      end
      if (cmd.cordic_step) begin
         if (!vy_ff[33]) begin
            vx_in = vx_ff + shy; vy_in = vy_ff - shx;
            ang_in = ang_ff + 34'(atan_q30(cnt_ff));
         end else begin
            vx_in = vx_ff - shy; vy_in = vy_ff + shx;
            ang_in = ang_ff - 34'(atan_q30(cnt_ff));
         end
         cnt_in = cnt_ff + 5'd1;
      end
      unique case (cmd.post_step)
         POST_ANGLE: raw_in = zero_ff ? 16'sd0 : 16'((ang_ff + 34'sd65536) >>> 17);
         POST_FILT: begin
            pitch_in = s_ff + 16'(mulf >>> 16);
            s_in = s_ff + 16'(mulf >>> 16);
            dp_in = 18'(16'(mulf >>> 16)) + 18'(gyro_ff);
         end
         POST_ACC: acc_in = 39'(pterm) + 39'(dterm);
         POST_EFF: begin
            if (effs > 24'sd16384) eff_in = EFFORT_ONE;
            else if (effs < -24'sd16384) eff_in = -EFFORT_ONE;
            else eff_in = 17'(effs);
         end
         POST_MIX: begin
            front_in = 16'(pf >> 14);
            back_in = 16'(pb >> 14);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_ff <= '0;
      end else begin
         s_ff <= s_in;
      end
      if (cmd.load) begin
         ax_ff <= accel_x;
         gyro_ff <= gyro_pitch_rate;
      end
      rem_ff <= rem_in; root_ff <= root_in; cnt_ff <= cnt_in;
      vx_ff <= vx_in; vy_ff <= vy_in; ang_ff <= ang_in; zero_ff <= zero_in;
      raw_ff <= raw_in; pitch_ff <= pitch_in; dp_ff <= dp_in;
      acc_ff <= acc_in; eff_ff <= eff_in; front_ff <= front_in; back_ff <= back_in;
      if (out_load) begin
         mf_ff <= front_ff; mb_ff <= back_ff; me_ff <= 16'(eff_ff);
      end
   end

   assign status.sqrt_last = (cnt_ff == 5'd0);
   assign status.cordic_last = (cnt_ff == LAST);
   assign motor_front = mf_ff;
   assign motor_back = mb_ff;
   assign control_effort = me_ff;
endmodule

// ===== hdl/tilt_pd_motor_mixer_top.sv =====
// tilt pd controller with two-motor mixer: each req item (accel x/y/z and
// gyro pitch rate) yields one rsp item (two motor speeds and the clamped
// effort); an item passes through the idle state that takes it, the
// bit-serial square root (one root bit a cycle), the iterative cordic (a
// setup step, then one rotation a cycle, rotations capped at 24), the
// post-processing steps (angle, filter, accumulate, effort, mix) and the
// output state that moves the result into the output register; one item is
// in work at a time, the next item is taken while a result still waits, and
// a finished item stays in the output state until the waiting result is taken
`include "tilt_pd_motor_mixer_top_assert.svh"
module tilt_pd_motor_mixer_top
   import tpm_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // accel_x, accel_y, accel_z, gyro_pitch_rate
   input  logic [63:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // motor_front, motor_back, control_effort
   output logic [47:0] rsp_tdata,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_wdata
);
   // configuration registers
   logic [15:0] p_gain_ff, d_gain_ff, smooth_ff;
   logic [14:0] scale_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         p_gain_ff <= 16'd10923;
         d_gain_ff <= 16'd10923;
         smooth_ff <= 16'd6554;
         scale_ff <= 15'd16384;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_P_GAIN: p_gain_ff <= csr_wdata;
            REG_D_GAIN: d_gain_ff <= csr_wdata;
            REG_SMOOTHING: smooth_ff <= csr_wdata;
            REG_MOTOR_SCALE: scale_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   cmd_type cmd;
   status_type status;
   logic busy, out_valid, start, out_taken, out_load;
   logic [15:0] mf, mb;
   logic signed [15:0] me;

   assign req_tready = !busy;
   assign start = req_tvalid && req_tready;
   assign out_taken = rsp_tvalid && rsp_tready;

   // result register loads when the controller leaves its output state
   tpm_ctrl u_ctrl (
      .clock, .reset, .start, .out_taken, .status, .cmd, .out_load, .busy, .out_valid
   );

   tpm_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock, .reset, .cmd, .status,
      .accel_x(req_tdata[15:0]), .accel_y(req_tdata[31:16]),
      .accel_z(req_tdata[47:32]), .gyro_pitch_rate(req_tdata[63:48]),
      .out_load,
      .p_gain(p_gain_ff), .d_gain(d_gain_ff), .smoothing(smooth_ff),
      .motor_scale(scale_ff),
      .motor_front(mf), .motor_back(mb), .control_effort(me)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata = {me, mb, mf};

   `TPM_ASSERT_IMPL(a_busy_no_accept, clock, reset, busy, !req_tready)
   `TPM_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

// ===== bench/tilt_pd_motor_mixer_checker.sv =====
module tilt_pd_motor_mixer_checker
   import tpm_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          motor_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // highest field first, so motor_front sits in the lowest bits
   typedef struct packed {
      logic signed [15:0] control_effort;
      logic [15:0]        motor_back;
      logic [15:0]        motor_front;
   } motor_cmd_type;

   localparam longint ARCTAN_Q30 [24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127
   };

   int gain_p, gain_d, lpf_weight, speed_scale;
   int pitch_lpf;
   motor_cmd_type motor_queue[$];

   function automatic longint unsigned radius_q8(longint unsigned n);
      longint unsigned res, one_bit;
      res = 0;
      one_bit = 64'h4000_0000_0000_0000;
      while (one_bit > n)
         one_bit = one_bit >> 2;
      while (one_bit != 0) begin
         if (n >= res + one_bit) begin
            n = n - (res + one_bit);
            res = (res >> 1) + one_bit;
         end else begin
            res = res >> 1;
         end
         one_bit = one_bit >> 2;
      end
      return res;
   endfunction

   function automatic int tilt_angle(int ax, int ay, int az);
      longint vx, vy, xo, ang;
      longint unsigned sq;
      sq = longint'(ay) * ay + longint'(az) * az;
      vx = longint'(radius_q8(sq << 16));
      vy = -longint'(ax) * 256;
      ang = 0;
      if (vx == 0 && vy == 0)
         return 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         xo = vx;
         if (vy >= 0) begin
            vx = vx + (vy >>> i);
            vy = vy - (xo >>> i);
            ang = ang + ARCTAN_Q30[i];
         end else begin
            vx = vx - (vy >>> i);
            vy = vy + (xo >>> i);
            ang = ang - ARCTAN_Q30[i];
         end
      end
      return int'((ang + 65536) >>> 17);
   endfunction

   // one controller step, advances the filtered pitch
   function automatic motor_cmd_type mix_motors(logic [63:0] d);
      motor_cmd_type m;
      int raw, prev, pitch;
      longint dp, acc, eff, front, back;
      raw = tilt_angle(int'($signed(d[15:0])), int'($signed(d[31:16])),
                       int'($signed(d[47:32])));
      prev = pitch_lpf;
      pitch = prev + int'((longint'(lpf_weight) * (raw - prev) + 32768) >>> 16);
      dp = longint'(pitch - prev) + longint'($signed(d[63:48]));
      acc = 2 * longint'(gain_p) * pitch + longint'(gain_d) * dp;
      eff = (3 * acc + 16384) >>> 15;
      pitch_lpf = pitch;
      if (eff > 16384) eff = 16384;
      if (eff < -16384) eff = -16384;
      front = (longint'(speed_scale) * (16384 - eff)) >>> 14;
      back = (longint'(speed_scale) * (16384 + eff)) >>> 14;
      m.motor_front = front[15:0];
      m.motor_back = back[15:0];
      m.control_effort = eff[15:0];
      return m;
   endfunction

   always @(posedge clock) begin
      motor_cmd_type want, got;
      if (reset) begin
         gain_p <= 10923;
         gain_d <= 10923;
         lpf_weight <= 6554;
         speed_scale <= 16384;
         pitch_lpf = 0;
         motor_queue.delete();
         fail_count <= 0;
         motor_pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_P_GAIN: gain_p <= int'(csr_wdata);
               REG_D_GAIN: gain_d <= int'(csr_wdata);
               REG_SMOOTHING: lpf_weight <= int'(csr_wdata);
               REG_MOTOR_SCALE: speed_scale <= int'(csr_wdata[14:0]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (motor_queue.size() == 0) begin
               $error("unexpected rsp item %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = motor_queue.pop_front();
               if (got.motor_front !== want.motor_front)
                  $error("motor_front: expected %0d got %0d",
                         want.motor_front, got.motor_front);
               if (got.motor_back !== want.motor_back)
                  $error("motor_back: expected %0d got %0d",
                         want.motor_back, got.motor_back);
               if (got.control_effort !== want.control_effort)
                  $error("control_effort: expected %0d got %0d",
                         want.control_effort, got.control_effort);
               if (got !== want)
                  fail_count <= fail_count + 1;
            end
         end
         if (req_tvalid && req_tready)
            motor_queue.push_back(mix_motors(req_tdata));
         motor_pending <= motor_queue.size();
      end
   end
endmodule

// ===== bench/tb_tilt_pd_motor_mixer_top.sv =====
module tb_tilt_pd_motor_mixer_top
   import tpm_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 5000;   // cycles without any handshake
   localparam int HOLD_CYCLES = 600;    // long receiver hold-off
   localparam int DRAIN_CYCLES = 100;   // > latency of one item

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;         // accel_x, accel_y, accel_z, gyro_pitch_rate
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;              // motor_front, motor_back, control_effort
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int  fail_count, motor_pending;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   logic hold_go = 1'b0;
   int  hold_left = 0;
   int  quiet_cycles = 0;

   always #10 clock = ~clock;

   tilt_pd_motor_mixer_top u_top (.*);

   tilt_pd_motor_mixer_checker u_check (.*);

   // receiver: random stall, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
      end else if (hold_go) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog: any stretch with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tilt_pd_motor_mixer_top regression: fail");
         $finish;
      end
   end

   // offer one item, with random idle cycles in front of it
   task automatic send_sample(input logic signed [15:0] ax, ay, az, gyro);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {gyro, az, ay, ax};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // write enable drops for one cycle between writes
   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and let every outstanding item come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (motor_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // mostly a plausible gravity vector with a tilt, sometimes anything
   task automatic random_sample();
      logic signed [15:0] ax, ay, az, gyro;
      if ($urandom_range(9) < 7) begin
         ax = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
         ay = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
         az = $urandom_range(1) ? 16'sd16384 - 16'($urandom_range(4000))
                                : -16'sd16384 + 16'($urandom_range(4000));
         gyro = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
      end else begin
         {ax, ay} = $urandom;
         {az, gyro} = $urandom;
      end
      send_sample(ax, ay, az, gyro);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset values of the registers
      send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);            // zero vector
      send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd32767);        // zero vector, gyro only
      send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd0);        // level
      send_sample(16'sd32767, 16'sd0, 16'sd0, 16'sd0);        // straight down
      send_sample(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);       // straight up
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_sample(16'sd0, -16'sd32768, -16'sd32768, 16'sd0);  // largest radius
      send_sample(-16'sd32768, 16'sd0, 16'sd1, 16'sd32767);   // positive clamp
      send_sample(16'sd32767, 16'sd0, 16'sd1, -16'sd32768);   // negative clamp
      send_sample(16'sd1, 16'sd0, 16'sd0, 16'sd0);
      send_sample(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd1, 16'sd0, -16'sd1);
      send_sample(16'sd0, 16'sd0, -16'sd1, 16'sd1);
      drain();

      // extremes of every register, upper scale bit must be dropped
      write_reg(REG_P_GAIN, 16'hFFFF);
      write_reg(REG_D_GAIN, 16'hFFFF);
      write_reg(REG_SMOOTHING, 16'hFFFF);
      write_reg(REG_MOTOR_SCALE, 16'hFFFF);
      send_sample(-16'sd32768, 16'sd0, 16'sd100, 16'sd32767);
      send_sample(16'sd32767, 16'sd0, 16'sd100, -16'sd32768);
      send_sample(16'sd12000, 16'sd3000, -16'sd15000, -16'sd500);
      send_sample(-16'sd9000, -16'sd200, 16'sd16000, 16'sd400);
      drain();
      write_reg(REG_P_GAIN, 16'h0000);
      write_reg(REG_D_GAIN, 16'h0000);
      write_reg(REG_SMOOTHING, 16'h0000);
      write_reg(REG_MOTOR_SCALE, 16'h0000);
      send_sample(-16'sd32768, 16'sd0, 16'sd100, 16'sd32767);
      send_sample(16'sd5000, 16'sd0, 16'sd16000, -16'sd32768);
      drain();

      // random phases, each with its own register setting and idle mix
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            3: begin send_idle_pct = 19; recv_stall_pct = 19; end
            4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            default: begin
               send_idle_pct = $urandom_range(50);
               recv_stall_pct = $urandom_range(50);
            end
         endcase
         case (phase)
            0: begin
               write_reg(REG_P_GAIN, 16'd10923);
               write_reg(REG_D_GAIN, 16'd10923);
               write_reg(REG_SMOOTHING, 16'd6554);
               write_reg(REG_MOTOR_SCALE, 16'd16384);
            end
            1: begin
               write_reg(REG_P_GAIN, 16'd65535);
               write_reg(REG_D_GAIN, 16'd0);
               write_reg(REG_SMOOTHING, 16'd65535);
               write_reg(REG_MOTOR_SCALE, 16'd32767);
            end
            2: begin
               write_reg(REG_P_GAIN, 16'd0);
               write_reg(REG_D_GAIN, 16'd65535);
               write_reg(REG_SMOOTHING, 16'd1);
               write_reg(REG_MOTOR_SCALE, 16'd1);
            end
            default: begin
               write_reg(REG_P_GAIN, 16'($urandom));
               write_reg(REG_D_GAIN, 16'($urandom));
               write_reg(REG_SMOOTHING, 16'($urandom));
               write_reg(REG_MOTOR_SCALE, 16'($urandom));
            end
         endcase
         for (int n = 0; n < 235; n++) begin
            // long hold-off early in the phase while items keep coming
            if (phase == 4 && n == 3) begin
               hold_go <= 1'b1;
               random_sample();
               hold_go <= 1'b0;
            end else begin
               random_sample();
            end
         end
         drain();
      end

      if (fail_count == 0)
         $display("tilt_pd_motor_mixer_top regression: pass");
      else
         $display("tilt_pd_motor_mixer_top regression: fail");
      $finish;
   end
endmodule
